>>> hw/rtl/plch_pkg.sv
// Shared types and constants of the per-class latency histogram.
// Holds the item structs, the configuration register map and the
// command/status bundles between controller and datapath.
package plch_pkg;

    // Configuration register map.
    localparam int unsigned CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ENABLE = 2'd0;
    localparam t_cfg_idx CFG_LOWER  = 2'd1;
    localparam t_cfg_idx CFG_UPPER  = 2'd2;

    localparam logic        ENABLE_RST = 1'b1;
    localparam logic [31:0] LOWER_RST  = 32'd0;
    localparam logic [31:0] UPPER_RST  = 32'd4096;

    // Input item kinds.
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [3:0]  frame_class;
        logic [31:0] rtt_us;
        logic [11:0] bin_index;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  class_out;
        logic [11:0] bin_out;
        logic [31:0] bin_count;
        logic [31:0] overflow_count;
        logic [31:0] underflow_count;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic classify;
        logic mem_read;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic clear_last;
        logic is_read;
        logic out_free;
    } t_dp_stat;

endpackage

>>> hw/rtl/plch_ctrl.sv
// Sequencing state machine of the per-class latency histogram.
// Depends on plch_pkg for the command and status bundles.
module plch_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  plch_pkg::t_dp_stat i_stat,
    output plch_pkg::t_dp_cmd  o_cmd
);
    import plch_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CLASS,
        S_READ,
        S_UPDATE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CLASS;
                end
            end
            S_CLASS: begin
                o_cmd.classify = 1'b1;
                n_state        = S_READ;
            end
            S_READ: begin
                o_cmd.mem_read = 1'b1;
                n_state        = S_UPDATE;
            end
            S_UPDATE: begin
                // A read result waits here until the output register is free.
                if (!i_stat.is_read || i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/plch_dp.sv
// Datapath of the per-class latency histogram: configuration registers,
// item classification, bin memory, class counters and output register.
// Depends on plch_pkg for item types, register map and control bundles.
module plch_dp #(
    parameter int NUM_CLASSES = 9,
    parameter int NUM_BINS    = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  plch_pkg::t_cfg_idx  i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  plch_pkg::t_in_item  i_in_data,
    input  plch_pkg::t_dp_cmd   i_cmd,
    output plch_pkg::t_dp_stat  o_stat,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output plch_pkg::t_out_item o_out_data
);
    import plch_pkg::*;

    localparam int DEPTH  = NUM_CLASSES * NUM_BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int BIN_W  = $clog2(NUM_BINS);
    localparam int CIDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam logic [31:0] NUM_CLASSES_W = 32'(NUM_CLASSES);
    localparam logic [31:0] NUM_BINS_W    = 32'(NUM_BINS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        OP_NONE,
        OP_BIN,
        OP_OVER,
        OP_UNDER
    } t_op;

    function automatic logic [31:0] sat_inc(input logic [31:0] value);
        return (value == '1) ? value : value + 32'd1;
    endfunction

    // Configuration.
    logic        r_enable;
    logic [31:0] r_lower;
    logic [31:0] r_upper;

    // Captured item.
    logic        r_is_read;
    logic [3:0]  r_cls;
    logic [31:0] r_rtt;
    logic [11:0] r_bin;

    // Classification results.
    t_op               r_op;
    logic [ADDR_W-1:0] r_addr;
    logic              r_cls_ok;
    logic              r_bin_ok;

    // Storage.
    logic [31:0]       mem [DEPTH];
    logic [31:0]       r_rd_data;
    logic [31:0]       r_over  [NUM_CLASSES];
    logic [31:0]       r_under [NUM_CLASSES];
    logic [ADDR_W-1:0] r_clr_addr;

    logic      r_out_valid;
    t_out_item r_out;

    // Classification logic.
    logic [31:0]       c_off;
    logic              c_cls_ok;
    logic              c_bin_ok;
    t_op               c_op;
    logic [BIN_W-1:0]  c_bin_off;
    logic              c_addr_ok;
    logic [ADDR_W-1:0] c_addr;
    logic [CIDX_W-1:0] cidx;

    assign c_off    = r_rtt - r_lower;
    assign c_cls_ok = (32'(r_cls) < NUM_CLASSES_W);
    assign c_bin_ok = (32'(r_bin) < NUM_BINS_W);

    always_comb begin
        priority if (r_is_read || !r_enable || !c_cls_ok) begin
            c_op = OP_NONE;
        end else if (r_rtt >= r_upper) begin
            c_op = OP_OVER;
        end else if (r_rtt < r_lower) begin
            c_op = OP_UNDER;
        end else if (c_off >= NUM_BINS_W) begin
            c_op = OP_OVER;
        end else begin
            c_op = OP_BIN;
        end
    end

    assign c_bin_off = r_is_read ? BIN_W'(r_bin) : c_off[BIN_W-1:0];
    assign c_addr_ok = r_is_read ? (c_cls_ok && c_bin_ok) : (c_op == OP_BIN);
    assign c_addr    = c_addr_ok
                     ? ADDR_W'(r_cls) * ADDR_W'(NUM_BINS) + ADDR_W'(c_bin_off)
                     : '0;

    assign cidx = r_cls[CIDX_W-1:0];

    // Configuration writes, always taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= ENABLE_RST;
            r_lower  <= LOWER_RST;
            r_upper  <= UPPER_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                CFG_LOWER:  r_lower  <= i_cfg_data;
                CFG_UPPER:  r_upper  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Item capture and classification.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_is_read <= (i_in_data.kind == KIND_READ);
            r_cls     <= i_in_data.frame_class;
            r_rtt     <= i_in_data.rtt_us;
            r_bin     <= i_in_data.bin_index;
        end
        if (i_cmd.classify) begin
            r_op     <= c_op;
            r_addr   <= c_addr;
            r_cls_ok <= c_cls_ok;
            r_bin_ok <= c_bin_ok;
        end
    end

    // Bin memory: one write port shared by the clear sweep and the update.
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [31:0]       mem_wdata;

    assign mem_we    = i_cmd.clear_step
                     || (i_cmd.commit && !r_is_read && (r_op == OP_BIN));
    assign mem_waddr = i_cmd.clear_step ? r_clr_addr : r_addr;
    assign mem_wdata = i_cmd.clear_step ? 32'd0 : sat_inc(r_rd_data);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.mem_read) begin
            r_rd_data <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step && (r_clr_addr != LAST_ADDR)) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // Class overflow and underflow counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_over[i]  <= '0;
                r_under[i] <= '0;
            end
        end else if (i_cmd.commit && !r_is_read) begin
            unique case (r_op)
                OP_OVER:  r_over[cidx]  <= sat_inc(r_over[cidx]);
                OP_UNDER: r_under[cidx] <= sat_inc(r_under[cidx]);
                OP_BIN, OP_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit && r_is_read) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_is_read) begin
            r_out.class_out       <= r_cls;
            r_out.bin_out         <= r_bin;
            r_out.bin_count       <= (r_cls_ok && r_bin_ok) ? r_rd_data : 32'd0;
            r_out.overflow_count  <= r_cls_ok ? r_over[cidx]  : 32'd0;
            r_out.underflow_count <= r_cls_ok ? r_under[cidx] : 32'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_stat.clear_last = (r_clr_addr == LAST_ADDR);
    assign o_stat.is_read    = r_is_read;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

endmodule

>>> hw/rtl/per_class_latency_histogram.sv
// Per-class latency histogram with underflow and overflow bins.
// A beat passes through capture, classify, memory read and update, the read-modify-write
// of the bin memory through its single write port, and a new beat is taken only once the
// last is through; a read result is registered at update, and a read waits there only
// while the previous result is still held. After reset the bin memory is swept to zero,
// one entry a cycle, all NUM_CLASSES*NUM_BINS entries (36864 by default), before any beat.
module per_class_latency_histogram #(
    parameter int NUM_CLASSES = 9,
    parameter int NUM_BINS    = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // Configuration write channel. Always ready.
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  plch_pkg::t_cfg_idx  i_cfg_index,
    input  logic [31:0]         i_cfg_data,

    // Input beats: record a sample or read a bin.
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  plch_pkg::t_in_item  i_in_data,

    // Result beats, one per read.
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output plch_pkg::t_out_item o_out_data
);
    import plch_pkg::*;

    // The controller walks each beat through the datapath; the two are
    // joined only by the command and status bundles.
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Configuration registers live in the datapath and take a write in any
    // cycle. The user must send writes only while the block is idle, so that no
    // beat in flight sees bounds change under it; the block does not enforce this.
    assign o_cfg_ready = 1'b1;

    plch_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath holds the bin memory and its clearing sweep, the class
    // counters and the output register, so a finished result can wait for
    // the consumer while the next beat is taken in.
    plch_dp #(
        .NUM_CLASSES (NUM_CLASSES),
        .NUM_BINS    (NUM_BINS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

>>> tb/per_class_latency_histogram_tb.sv
// Self-checking testbench for the per-class latency histogram.
// Drives record and read beats through valid/ready, predicts every read result
// from its own copy of the counter store, and uses the types of plch_pkg.
module per_class_latency_histogram_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plch_pkg::*;

    localparam int NUM_CLASSES = 9;
    localparam int NUM_BINS    = 4096;
    localparam int STORE_DEPTH = NUM_CLASSES * NUM_BINS;

    // The block needs a full sweep of its store after reset, so the limit allows for it
    // plus many times the slowest pass over all beats with every stall mode.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;    // a beat passes capture, classify, memory read and update
    localparam int HOLD_CYCLES   = 400;  // long receiver hold-off to fill the block
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_BEATS   = 92;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_op;

    // One row of the directed table: either a register write or a beat. A beat row
    // may carry a hand-written result that replaces the predicted one.
    typedef struct {
        t_row_op     op;
        t_cfg_idx    idx;
        logic [31:0] val;
        t_in_item    item;
        bit          typed;
        t_out_item   res;
    } t_dir_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    t_cfg_idx  i_cfg_index = CFG_ENABLE;
    logic [31:0] i_cfg_data = 32'd0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    per_class_latency_histogram #(
        .NUM_CLASSES(NUM_CLASSES),
        .NUM_BINS   (NUM_BINS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // Shadow of the counter store and of the configuration registers.
    logic [31:0] bin_mem   [STORE_DEPTH];
    logic [31:0] over_mem  [NUM_CLASSES];
    logic [31:0] under_mem [NUM_CLASSES];
    logic        cfg_en    = ENABLE_RST;
    logic [31:0] cfg_lower = LOWER_RST;
    logic [31:0] cfg_upper = UPPER_RST;

    // Read results that have been accepted as beats but not yet seen at the output.
    t_out_item pending_reads[$];
    t_dir_row  dir_rows[$];

    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   send_idle_pct  = 0;
    int   stall_pct      = 0;
    logic hold_req       = 1'b0;
    logic hold_ack       = 1'b0;
    int   hold_left      = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a run that never drains ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stalls per the current mode, plus a long hold-off on request.
    // The hold-off is counted here so that the sender keeps offering beats meanwhile.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack    <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Output monitor: every result beat is matched against the oldest pending read.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reads.size() == 0) begin
                $display("%0t: result beat with no read pending, expected none, got class %0d bin %0d",
                         $time, o_out_data.class_out, o_out_data.bin_out);
                mismatch_count++;
            end else begin
                want = pending_reads.pop_front();
                check_field("class_out", 32'(want.class_out), 32'(o_out_data.class_out));
                check_field("bin_out", 32'(want.bin_out), 32'(o_out_data.bin_out));
                check_field("bin_count", want.bin_count, o_out_data.bin_count);
                check_field("overflow_count", want.overflow_count, o_out_data.overflow_count);
                check_field("underflow_count", want.underflow_count, o_out_data.underflow_count);
            end
        end
    end

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == MAX32) ? v : v + 32'd1;
    endfunction

    // Applies one accepted beat to the shadow store. A read queues its result; a row
    // with a hand-written result queues that instead of the computed one.
    function automatic void hist_apply(t_in_item it, bit typed, t_out_item typed_res);
        t_out_item   res;
        logic [31:0] off;
        int          cls;
        cls = int'(it.frame_class);
        if (it.kind == KIND_RECORD) begin
            if (!cfg_en || cls >= NUM_CLASSES)
                return;
            if (it.rtt_us >= cfg_upper) begin
                over_mem[cls] = sat_inc(over_mem[cls]);
            end else if (it.rtt_us < cfg_lower) begin
                under_mem[cls] = sat_inc(under_mem[cls]);
            end else begin
                off = it.rtt_us - cfg_lower;
                if (off >= 32'(NUM_BINS))
                    over_mem[cls] = sat_inc(over_mem[cls]);
                else
                    bin_mem[cls * NUM_BINS + int'(off)] =
                        sat_inc(bin_mem[cls * NUM_BINS + int'(off)]);
            end
            return;
        end
        res.class_out       = it.frame_class;
        res.bin_out         = it.bin_index;
        res.bin_count       = '0;
        res.overflow_count  = '0;
        res.underflow_count = '0;
        if (cls < NUM_CLASSES) begin
            if (int'(it.bin_index) < NUM_BINS)
                res.bin_count = bin_mem[cls * NUM_BINS + int'(it.bin_index)];
            res.overflow_count  = over_mem[cls];
            res.underflow_count = under_mem[cls];
        end
        pending_reads.push_back(typed ? typed_res : res);
    endfunction

    // Offers one beat and waits for it to be taken. Valid stays high into the next
    // call unless an idle gap is drawn, so back-to-back beats need no extra edge.
    task automatic push_item(t_in_item it, bit typed, t_out_item typed_res);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        hist_apply(it, typed, typed_res);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Drops valid and waits until every read has returned and any record still in
    // the pipeline has had time to land, so a register write cannot overtake it.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reads.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ENABLE: cfg_en    = val[0];
            CFG_LOWER:  cfg_lower = val;
            CFG_UPPER:  cfg_upper = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_idle(t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct <= 0;  end
            IDLE_SENDER:   begin send_idle_pct = 46; stall_pct <= 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct <= 46; end
            default:       begin send_idle_pct = 30; stall_pct <= 30; end
        endcase
    endtask

    function automatic t_in_item mk_item(logic kind, int cls, logic [31:0] rtt, int bin);
        t_in_item it;
        it.kind        = kind;
        it.frame_class = 4'(cls);
        it.rtt_us      = rtt;
        it.bin_index   = 12'(bin);
        return it;
    endfunction

    function automatic void add_cfg(t_cfg_idx idx, logic [31:0] val);
        t_dir_row r;
        r.op    = ROW_CFG;
        r.idx   = idx;
        r.val   = val;
        r.item  = '0;
        r.typed = 1'b0;
        r.res   = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_item(logic kind, int cls, logic [31:0] rtt, int bin);
        t_dir_row r;
        r.op    = ROW_ITEM;
        r.idx   = CFG_ENABLE;
        r.val   = '0;
        r.item  = mk_item(kind, cls, rtt, bin);
        r.typed = 1'b0;
        r.res   = '0;
        dir_rows.push_back(r);
    endfunction

    // A read whose result is obvious from the table above it.
    function automatic void add_typed(int cls, int bin, logic [31:0] cnt,
                                      logic [31:0] ovf, logic [31:0] unf);
        t_dir_row r;
        r.op    = ROW_ITEM;
        r.idx   = CFG_ENABLE;
        r.val   = '0;
        r.item  = mk_item(KIND_READ, cls, 32'd0, bin);
        r.typed = 1'b1;
        r.res   = '{class_out: 4'(cls), bin_out: 12'(bin), bin_count: cnt,
                    overflow_count: ovf, underflow_count: unf};
        dir_rows.push_back(r);
    endfunction

    // Mostly well-formed beats aimed at the bin window and its edges of the current
    // bounds, with reads of the low bins that those records hit; the rest is noise
    // over every field, including classes beyond the last one.
    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        if ($urandom_range(99) < 75) begin
            it.frame_class = 4'($urandom_range(NUM_CLASSES - 1));
            it.rtt_us      = $urandom;
            it.bin_index   = 12'($urandom_range(31));
            if ($urandom_range(99) < 55) begin
                it.kind = KIND_RECORD;
                pick = $urandom_range(7);
                case (pick)
                    0: it.rtt_us = cfg_upper;
                    1: it.rtt_us = cfg_upper - 32'd1;
                    2: it.rtt_us = cfg_lower - 32'd1;
                    3: it.rtt_us = cfg_lower + 32'(NUM_BINS - 1);
                    4: it.rtt_us = cfg_lower + 32'(NUM_BINS);
                    default: it.rtt_us = cfg_lower + 32'($urandom_range(31));
                endcase
            end else begin
                it.kind = KIND_READ;
                if ($urandom_range(9) == 0)
                    it.bin_index = 12'(NUM_BINS - 1);
            end
        end else begin
            it.kind        = logic'($urandom_range(1));
            it.frame_class = 4'($urandom_range(15));
            it.rtt_us      = $urandom;
            it.bin_index   = 12'($urandom_range(4095));
        end
        return it;
    endfunction

    // Register settings of each random phase; every register is rewritten each time.
    task automatic program_phase(int p);
        logic        en;
        logic [31:0] lo;
        logic [31:0] up;
        en = 1'b1;
        case (p)
            0: begin lo = 32'd0;                         up = 32'd4096; end
            1: begin lo = $urandom;                      up = lo + 32'($urandom_range(16, 6000)); end
            2: begin lo = 32'd0;                         up = MAX32; end
            3: begin lo = MAX32;                         up = MAX32; end
            4: begin lo = 32'($urandom_range(100));      up = 32'd0; end
            5: begin en = 1'b0; lo = 32'd0;              up = 32'd4096; end
            6: begin lo = 32'($urandom_range(2000, 3000)); up = 32'($urandom_range(1999)); end
            7: begin lo = $urandom;                      up = lo + 32'($urandom_range(8192)); end
            8: begin lo = 32'($urandom_range(64));       up = lo + 32'($urandom_range(4200)); end
            default: begin lo = 32'd0;                   up = 32'd4096; end
        endcase
        wait_idle();
        cfg_write(CFG_ENABLE, {31'd0, en});
        cfg_write(CFG_LOWER, lo);
        cfg_write(CFG_UPPER, up);
    endtask

    initial begin
        t_in_item it;
        int       counted;

        foreach (bin_mem[i]) bin_mem[i] = '0;
        foreach (over_mem[i]) over_mem[i] = '0;
        foreach (under_mem[i]) under_mem[i] = '0;

        // Reset bounds first: empty store, the edges of the bin window, samples
        // at and above the upper bound, and classes beyond the last one.
        add_typed(0, 0, 32'd0, 32'd0, 32'd0);
        add_typed(8, 4095, 32'd0, 32'd0, 32'd0);
        add_typed(15, 4095, 32'd0, 32'd0, 32'd0);
        add_item(KIND_RECORD, 0, 32'd0, 0);
        add_item(KIND_RECORD, 0, 32'd4095, 0);
        add_item(KIND_RECORD, 0, 32'd4096, 0);
        add_item(KIND_RECORD, 0, MAX32, 4095);
        add_item(KIND_RECORD, 8, 32'd100, 0);
        add_item(KIND_RECORD, 15, 32'd5, 0);
        add_typed(0, 0, 32'd1, 32'd2, 32'd0);
        add_item(KIND_READ, 0, 32'd0, 4095);
        add_item(KIND_READ, 8, MAX32, 100);
        // A raised lower bound: below it, at it, the last bin and one past the last bin.
        add_cfg(CFG_LOWER, 32'd1000);
        add_cfg(CFG_UPPER, MAX32);
        add_item(KIND_RECORD, 1, 32'd999, 0);
        add_item(KIND_RECORD, 1, 32'd1000, 0);
        add_item(KIND_RECORD, 1, 32'd5095, 0);
        add_item(KIND_RECORD, 1, 32'd5096, 0);
        add_item(KIND_READ, 1, 32'd0, 0);
        add_item(KIND_READ, 1, 32'd0, 4095);
        // Crossed bounds leave no bin reachable.
        add_cfg(CFG_LOWER, 32'd6000);
        add_cfg(CFG_UPPER, 32'd5000);
        add_item(KIND_RECORD, 2, 32'd5500, 0);
        add_item(KIND_RECORD, 2, 32'd5000, 0);
        add_item(KIND_READ, 2, 32'd0, 0);
        // Both bounds at the top of the range.
        add_cfg(CFG_LOWER, MAX32);
        add_cfg(CFG_UPPER, MAX32);
        add_item(KIND_RECORD, 4, MAX32 - 32'd1, 0);
        add_item(KIND_RECORD, 4, MAX32, 0);
        add_typed(4, 0, 32'd0, 32'd1, 32'd1);
        // Recording switched off.
        add_cfg(CFG_ENABLE, 32'd0);
        add_cfg(CFG_LOWER, 32'd0);
        add_item(KIND_RECORD, 3, 32'd7, 0);
        add_typed(3, 7, 32'd0, 32'd0, 32'd0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idle(IDLE_NONE);
        foreach (dir_rows[i]) begin
            if (dir_rows[i].op == ROW_CFG) begin
                wait_idle();
                cfg_write(dir_rows[i].idx, dir_rows[i].val);
            end else begin
                push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            program_phase(p);
            set_idle(t_idle_mode'(p % 4));
            // In the first phase the receiver holds off while beats keep coming,
            // so the held result backs up into the input.
            if (p == 0)
                hold_req <= ~hold_req;
            counted = 0;
            while (counted < PHASE_BEATS) begin
                it = random_item();
                counted++;
                push_item(it, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_reads.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
